// File: rtl/core/olte_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list table engine package
// Beat types, action codes and status codes shared by the list engine files.
// ----------------------------------------------------------------------------
package olte_pkg;

  // Action codes carried in the input beat.
  typedef enum logic [3:0] {
    ActPushFront    = 4'd0,
    ActPushBack     = 4'd1,
    ActPopFront     = 4'd2,
    ActInsertUnique = 4'd3,
    ActRemoveValue  = 4'd4,
    ActExists       = 4'd5,
    ActReadIndex    = 4'd6,
    ActFront        = 4'd7,
    ActBack         = 4'd8,
    ActClear        = 4'd9
  } action_e;

  // Status codes carried in the output beat.
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StRange = 2'd2,
    StFull  = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] value;
    logic [5:0]  position;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        found;
    logic [31:0] read_value;
    logic [6:0]  occupancy;
  } out_item_t;

endpackage

// File: rtl/core/olte_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olte_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/olte_seq.sv
// ----------------------------------------------------------------------------
// List engine sequencer
// Decodes one action at a time and walks the store through one shared slot
// adder and one shared equality compare.
// ----------------------------------------------------------------------------
module olte_seq #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  parameter int CNT_W  = $clog2(DEPTH + 1),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  olte_pkg::in_item_t   in_item_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output olte_pkg::out_item_t  res_o,
  output logic [CNT_W-1:0]     count_o,
  output logic                 ram_we_o,
  output logic [ADDR_W-1:0]    ram_waddr_o,
  output logic [DATA_W-1:0]    ram_wdata_o,
  output logic                 ram_re_o,
  output logic [ADDR_W-1:0]    ram_raddr_o,
  input  logic [DATA_W-1:0]    ram_rdata_i
);

  localparam int PosW = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [CNT_W:0]   DepthSum = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] DepthM1  = CNT_W'(DEPTH - 1);

  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SExec = 6'b000010,
    SSrch = 6'b000100,
    SShft = 6'b001000,
    SRdwt = 6'b010000,
    SResp = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [3:0]            act_q, act_d;
  logic [DATA_W-1:0]     val_q, val_d;
  logic [5:0]            pos_q, pos_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ADDR_W-1:0]     start_q, start_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  chk_q, chk_d;
  logic [ADDR_W-1:0]     chk_slot_q, chk_slot_d;
  logic [ADDR_W-1:0]     hole_q, hole_d;
  logic                  pend_q, pend_d;
  logic [ADDR_W-1:0]     pend_slot_q, pend_slot_d;
  olte_pkg::status_e     status_q, status_d;
  logic                  found_q, found_d;
  logic [31:0]           rd_q, rd_d;

  logic [CNT_W-1:0]      offset;
  logic [CNT_W:0]        sum;
  logic [ADDR_W-1:0]     slot;
  logic                  full, empty, pos_oob, match;

  assign full    = (count_q == DepthCnt);
  assign empty   = (count_q == '0);
  assign pos_oob = (PosW'(pos_q) >= PosW'(count_q));
  assign match   = chk_q && (ram_rdata_i == val_q);

  // Shared slot adder: slot = (start + offset) mod DEPTH.
  always_comb begin
    offset = '0;
    case (state_q)
      SExec: begin
        case (act_q)
          olte_pkg::ActPushFront: offset = DepthM1;
          olte_pkg::ActPushBack:  offset = count_q;
          olte_pkg::ActReadIndex: offset = CNT_W'(pos_q);
          olte_pkg::ActBack:      offset = count_q - CNT_W'(1);
          default:                offset = '0;
        endcase
      end
      SSrch, SShft: offset = idx_q;
      SRdwt:        offset = CNT_W'(1);
      default:      offset = '0;
    endcase
    sum = (CNT_W + 1)'(start_q) + (CNT_W + 1)'(offset);
    if (sum >= DepthSum) begin
      sum = sum - DepthSum;
    end
    slot = sum[ADDR_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    val_d       = val_q;
    pos_d       = pos_q;
    count_d     = count_q;
    start_d     = start_q;
    idx_d       = idx_q;
    chk_d       = chk_q;
    chk_slot_d  = chk_slot_q;
    hole_d      = hole_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    status_d    = status_q;
    found_d     = found_q;
    rd_d        = rd_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = slot;
    ram_wdata_o = val_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = slot;

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          act_d    = in_item_i.action;
          val_d    = DATA_W'(in_item_i.value);
          pos_d    = in_item_i.position;
          status_d = olte_pkg::StOk;
          found_d  = 1'b0;
          rd_d     = '0;
          state_d  = SExec;
        end
      end

      SExec: begin
        state_d = SResp;
        case (act_q)
          olte_pkg::ActPushFront: begin
            if (full) begin
              status_d = olte_pkg::StFull;
            end else begin
              ram_we_o = 1'b1;
              start_d  = slot;
              count_d  = count_q + CNT_W'(1);
              found_d  = 1'b1;
            end
          end
          olte_pkg::ActPushBack: begin
            if (full) begin
              status_d = olte_pkg::StFull;
            end else begin
              ram_we_o = 1'b1;
              count_d  = count_q + CNT_W'(1);
              found_d  = 1'b1;
            end
          end
          olte_pkg::ActPopFront, olte_pkg::ActFront, olte_pkg::ActBack,
          olte_pkg::ActReadIndex: begin
            if (empty) begin
              status_d = olte_pkg::StEmpty;
            end else if ((act_q == olte_pkg::ActReadIndex) && pos_oob) begin
              status_d = olte_pkg::StRange;
            end else begin
              ram_re_o = 1'b1;
              state_d  = SRdwt;
            end
          end
          olte_pkg::ActInsertUnique: begin
            idx_d   = '0;
            chk_d   = 1'b0;
            state_d = SSrch;
          end
          olte_pkg::ActRemoveValue, olte_pkg::ActExists: begin
            if (empty) begin
              status_d = olte_pkg::StEmpty;
            end else begin
              idx_d   = '0;
              chk_d   = 1'b0;
              state_d = SSrch;
            end
          end
          olte_pkg::ActClear: begin
            count_d = '0;
            start_d = '0;
            found_d = 1'b1;
          end
          default: ;
        endcase
      end

      // One read is issued per cycle; its data is compared in the next cycle.
      SSrch: begin
        if (match) begin
          case (act_q)
            olte_pkg::ActExists: begin
              found_d = 1'b1;
              state_d = SResp;
            end
            olte_pkg::ActRemoveValue: begin
              hole_d  = chk_slot_q;
              pend_d  = 1'b0;
              state_d = SShft;
            end
            default: state_d = SResp;
          endcase
        end else if (idx_q >= count_q) begin
          state_d = SResp;
          if (act_q == olte_pkg::ActInsertUnique) begin
            if (full) begin
              status_d = olte_pkg::StFull;
            end else begin
              ram_we_o = 1'b1;
              count_d  = count_q + CNT_W'(1);
              found_d  = 1'b1;
            end
          end
        end else begin
          ram_re_o   = 1'b1;
          chk_slot_d = slot;
          chk_d      = 1'b1;
          idx_d      = idx_q + CNT_W'(1);
        end
      end

      // Close the gap: each later entry moves one slot toward the front.
      SShft: begin
        if (pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = hole_q;
          ram_wdata_o = ram_rdata_i;
          hole_d      = pend_slot_q;
        end
        if (idx_q < count_q) begin
          ram_re_o    = 1'b1;
          pend_slot_d = slot;
          pend_d      = 1'b1;
          idx_d       = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CNT_W'(1);
            found_d = 1'b1;
            state_d = SResp;
          end
        end
      end

      SRdwt: begin
        rd_d    = 32'(ram_rdata_i);
        found_d = 1'b1;
        if (act_q == olte_pkg::ActPopFront) begin
          start_d = slot;
          count_d = count_q - CNT_W'(1);
        end
        state_d = SResp;
      end

      SResp: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      start_q <= '0;
      chk_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      start_q <= start_d;
      chk_q   <= chk_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    val_q       <= val_d;
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    chk_slot_q  <= chk_slot_d;
    hole_q      <= hole_d;
    pend_slot_q <= pend_slot_d;
    status_q    <= status_d;
    found_q     <= found_d;
    rd_q        <= rd_d;
  end

  assign in_ready_o       = (state_q == SIdle);
  assign res_valid_o      = (state_q == SResp);
  assign res_o.status     = status_q;
  assign res_o.found      = found_q;
  assign res_o.read_value = rd_q;
  assign res_o.occupancy  = 7'(count_q);
  assign count_o          = count_q;

endmodule

// File: rtl/core/ordered_list_table_engine.sv
// Steps: push, clear and errors found at decode pass SExec and SResp; pop front,
// front, back and read index pass SExec, SRdwt and SResp; insert unique and
// exists walk the list in SSrch, one RAM read a cycle; a removal then shifts in SShft.
// Throughput: one action at a time; the input is ready again in the cycle
// after the result has been handed to the output register.
// Reset: the list is empty after reset; the store itself is not cleared.
// ----------------------------------------------------------------------------
// Ordered list table engine
// Bounded ordered list kept in a circular RAM, with front and back inserts,
// front pop, set insert, value removal, membership test and indexed reads.
// ----------------------------------------------------------------------------
module ordered_list_table_engine #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  olte_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output olte_pkg::out_item_t out_item_o
);

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int AddrW = $clog2(DEPTH);

  // Sequencer result handoff. The sequencer holds its result until the
  // output register can take it, so the output side may stall freely.
  logic                res_valid;
  logic                res_ready;
  olte_pkg::out_item_t res;
  logic [CntW-1:0]     count;

  // Store port signals.
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AddrW-1:0]    ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  // Output register.
  logic                out_valid_q, out_valid_d;
  olte_pkg::out_item_t out_item_q;

  olte_seq #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W),
    .CNT_W  (CntW),
    .ADDR_W (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .count_o     (count),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Entries are stored in circular order starting at the front slot. Only
  // live entries are ever read, so the store needs no clearing.
  olte_ram #(
    .Width (DATA_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a new result when it is empty or when its
  // current beat leaves in the same cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // The element count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(DEPTH))
    else $error("list count exceeds depth");

  // An accepted input beat keeps the engine busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("engine ready right after accepting a beat");

  // A result handed off by the sequencer shows up on the output next cycle.
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> (out_valid_o && (out_item_o == $past(res))))
    else $error("result handoff lost");

  // Any error status comes with no found flag and a zero data value.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != olte_pkg::StOk)) |->
      (!out_item_o.found && (out_item_o.read_value == '0)))
    else $error("error result carries data");
`endif

endmodule

// File: tb/sv/tb_ordered_list_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list table engine testbench
// Drives list actions through the valid/ready input channel and checks every
// result beat against an in-bench model of the circular list store. Directed
// tests cover the empty, full and out-of-range cases; random traffic then runs
// under three idle mixes, a long output hold-off and sender pauses.
// ----------------------------------------------------------------------------
module tb_ordered_list_table_engine;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 11;
  localparam int DEPTH           = 64;
  localparam int DATA_W          = 32;
  // Outlasts a value removal, which walks and shifts the list.
  localparam int DRAIN_CYCLES    = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  // Several times the longest quiet stretch of a correct run (the hold-off).
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SEGMENT_ITEMS   = 100;
  localparam int POOL_SIZE       = 8;
  // Codes above ActClear are unused; the block answers them without effect.
  localparam logic [3:0] ActTopCode = 4'hF;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  olte_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  olte_pkg::out_item_t out_item;

  // Expected result beats, oldest first.
  olte_pkg::out_item_t pending_results[$];
  olte_pkg::out_item_t expected_beat;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;

  // Idle mix in percent per cycle, and a pending output hold-off request.
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 48;
  int          hold_request  = 0;

  // Model state: circular store, element count and slot of the front element.
  logic [DATA_W-1:0] list_mem [DEPTH];
  int                list_len  = 0;
  int                head_slot = 0;

  logic [31:0]       value_pool [POOL_SIZE];
  olte_pkg::action_e insert_acts [3] = '{olte_pkg::ActPushFront, olte_pkg::ActPushBack,
                                         olte_pkg::ActInsertUnique};
  olte_pkg::action_e delete_acts [2] = '{olte_pkg::ActPopFront, olte_pkg::ActRemoveValue};
  olte_pkg::action_e query_acts  [4] = '{olte_pkg::ActExists, olte_pkg::ActReadIndex,
                                         olte_pkg::ActFront, olte_pkg::ActBack};

  always #(CLK_PERIOD / 2) clk = ~clk;

  ordered_list_table_engine #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // --------------------------------------------------------------------------
  // List model
  // --------------------------------------------------------------------------

  function automatic int slot_at(int idx);
    return (head_slot + idx) % DEPTH;
  endfunction

  // Index of the first element equal to the value, or -1 when absent.
  function automatic int find_value(logic [DATA_W-1:0] val);
    for (int i = 0; i < list_len; i++) begin
      if (list_mem[slot_at(i)] == val) return i;
    end
    return -1;
  endfunction

  // Applies one action to the model and returns the result beat it produces.
  function automatic olte_pkg::out_item_t list_apply_action(olte_pkg::in_item_t beat);
    olte_pkg::out_item_t res;
    int                  hit;
    logic                full;
    logic                empty;
    res    = '0;
    res.status = olte_pkg::StOk;
    full   = (list_len >= DEPTH);
    empty  = (list_len == 0);
    hit    = find_value(beat.value[DATA_W-1:0]);
    case (beat.action)
      olte_pkg::ActPushFront: begin
        if (full) begin
          res.status = olte_pkg::StFull;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          list_mem[head_slot] = beat.value[DATA_W-1:0];
          list_len++;
          res.found = 1'b1;
        end
      end
      olte_pkg::ActPushBack: begin
        if (full) begin
          res.status = olte_pkg::StFull;
        end else begin
          list_mem[slot_at(list_len)] = beat.value[DATA_W-1:0];
          list_len++;
          res.found = 1'b1;
        end
      end
      olte_pkg::ActPopFront: begin
        if (empty) begin
          res.status = olte_pkg::StEmpty;
        end else begin
          res.read_value = 32'(list_mem[head_slot]);
          head_slot = slot_at(1);
          list_len--;
          res.found = 1'b1;
        end
      end
      olte_pkg::ActInsertUnique: begin
        // A value already present is left alone, even in a full store.
        if (hit < 0) begin
          if (full) begin
            res.status = olte_pkg::StFull;
          end else begin
            list_mem[slot_at(list_len)] = beat.value[DATA_W-1:0];
            list_len++;
            res.found = 1'b1;
          end
        end
      end
      olte_pkg::ActRemoveValue: begin
        if (empty) begin
          res.status = olte_pkg::StEmpty;
        end else if (hit >= 0) begin
          // Later entries move one place toward the front to close the gap.
          for (int i = hit; i + 1 < list_len; i++) begin
            list_mem[slot_at(i)] = list_mem[slot_at(i + 1)];
          end
          list_len--;
          res.found = 1'b1;
        end
      end
      olte_pkg::ActExists: begin
        if (empty) begin
          res.status = olte_pkg::StEmpty;
        end else begin
          res.found = (hit >= 0);
        end
      end
      olte_pkg::ActReadIndex: begin
        if (empty) begin
          res.status = olte_pkg::StEmpty;
        end else if (int'(beat.position) >= list_len) begin
          res.status = olte_pkg::StRange;
        end else begin
          res.read_value = 32'(list_mem[slot_at(int'(beat.position))]);
          res.found = 1'b1;
        end
      end
      olte_pkg::ActFront: begin
        if (empty) begin
          res.status = olte_pkg::StEmpty;
        end else begin
          res.read_value = 32'(list_mem[head_slot]);
          res.found = 1'b1;
        end
      end
      olte_pkg::ActBack: begin
        if (empty) begin
          res.status = olte_pkg::StEmpty;
        end else begin
          res.read_value = 32'(list_mem[slot_at(list_len - 1)]);
          res.found = 1'b1;
        end
      end
      olte_pkg::ActClear: begin
        list_len  = 0;
        head_slot = 0;
        res.found = 1'b1;
      end
      default: begin
      end
    endcase
    res.occupancy = 7'(list_len);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one beat from a falling edge and returns at the falling edge after
  // it was accepted. Valid is left high so that a following beat can go out
  // back to back; whoever stops sending must lower it.
  task automatic send_item(input logic [3:0] act, input logic [31:0] val,
                           input logic [5:0] pos);
    olte_pkg::in_item_t beat;
    beat.action   = act;
    beat.value    = val;
    beat.position = pos;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_item  = beat;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(list_apply_action(beat));
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result beat has come back.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Values are drawn from a small pool, from the live list, or at random, so
  // that searches and removals hit often enough.
  task automatic send_random_item(input bit grow);
    int unsigned pick;
    int unsigned ins_pct;
    int unsigned del_pct;
    int unsigned pos_max;
    logic [3:0]  act;
    logic [31:0] val;
    logic [5:0]  pos;
    ins_pct = grow ? 75 : 20;
    del_pct = grow ? 8 : 50;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      act = 4'($urandom_range(int'(olte_pkg::ActClear) + 1, int'(ActTopCode)));
    end else if (pick < 3) begin
      act = olte_pkg::ActClear;
    end else if (pick < ins_pct) begin
      act = insert_acts[$urandom_range(0, 2)];
    end else if (pick < ins_pct + del_pct) begin
      act = delete_acts[$urandom_range(0, 1)];
    end else begin
      act = query_acts[$urandom_range(0, 3)];
    end

    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick < 7 && list_len > 0) begin
      val = 32'(list_mem[slot_at($urandom_range(0, list_len - 1))]);
    end else begin
      val = $urandom;
    end

    // Mostly indexes near the live range, including one past the back.
    pos_max = (list_len > DEPTH - 1) ? DEPTH - 1 : list_len;
    if ($urandom_range(0, 3) == 0) pos = 6'($urandom_range(0, DEPTH - 1));
    else pos = 6'($urandom_range(0, pos_max));
    send_item(act, val, pos);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Receiver ready, with random stalls and a long hold-off on request.
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ready = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic report_field(input string field, input logic [31:0] expected,
                              input logic [31:0] actual);
    mismatch_count++;
    $display("%0t ns: %s mismatch, expected 'h%0h, got 'h%0h",
             $time, field, expected, actual);
  endtask

  // Each accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result beat with none expected, got 'h%0h",
                 $time, out_item);
      end else begin
        expected_beat = pending_results.pop_front();
        if (out_item.status !== expected_beat.status)
          report_field("status", 32'(expected_beat.status), 32'(out_item.status));
        if (out_item.found !== expected_beat.found)
          report_field("found", 32'(expected_beat.found), 32'(out_item.found));
        if (out_item.read_value !== expected_beat.read_value)
          report_field("read_value", expected_beat.read_value, out_item.read_value);
        if (out_item.occupancy !== expected_beat.occupancy)
          report_field("occupancy", 32'(expected_beat.occupancy),
                       32'(out_item.occupancy));
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no beat moved for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every action that needs an element, sent to the list left empty by reset.
  task automatic test_empty_list();
    send_item(olte_pkg::ActPopFront, $urandom, '0);
    send_item(olte_pkg::ActRemoveValue, $urandom, '0);
    send_item(olte_pkg::ActExists, $urandom, '0);
    send_item(olte_pkg::ActReadIndex, $urandom, '0);
    send_item(olte_pkg::ActFront, $urandom, '0);
    send_item(olte_pkg::ActBack, $urandom, '0);
  endtask

  // Field extremes, set insert of present and absent values, range errors,
  // interior and last-entry removal, unused codes and clear.
  task automatic test_basic_actions();
    send_item(olte_pkg::ActPushBack, '0, '0);
    send_item(olte_pkg::ActPushFront, '1, '1);
    send_item(olte_pkg::ActInsertUnique, '0, '0);
    send_item(olte_pkg::ActInsertUnique, 32'h1234_5678, '0);
    send_item(olte_pkg::ActExists, 32'h1234_5678, '0);
    send_item(olte_pkg::ActExists, 32'hDEAD_BEEF, '0);
    send_item(olte_pkg::ActReadIndex, $urandom, 6'd0);
    send_item(olte_pkg::ActReadIndex, $urandom, 6'd2);
    send_item(olte_pkg::ActReadIndex, $urandom, '1);
    send_item(olte_pkg::ActFront, '0, '0);
    send_item(olte_pkg::ActBack, '1, '0);
    send_item(olte_pkg::ActRemoveValue, 32'hDEAD_BEEF, '0);
    // Removes the middle entry, which pulls the last one forward.
    send_item(olte_pkg::ActRemoveValue, '0, '0);
    send_item(olte_pkg::ActPopFront, '0, '0);
    // The only entry left goes, which must leave the list empty.
    send_item(olte_pkg::ActRemoveValue, 32'h1234_5678, '0);
    send_item(4'(int'(olte_pkg::ActClear) + 1), '1, '1);
    send_item(ActTopCode, '1, '1);
    send_item(olte_pkg::ActPushBack, $urandom, '0);
    send_item(olte_pkg::ActClear, $urandom, 6'($urandom));
  endtask

  // Fills the store, checks that inserts are refused, wraps the front pointer
  // and pops everything out again, one pop beyond empty.
  task automatic test_full_store();
    send_item(olte_pkg::ActClear, '0, '0);
    for (int i = 0; i < DEPTH; i++) begin
      send_item(olte_pkg::ActPushBack, {26'($urandom), 6'(i)}, '0);
    end
    send_item(olte_pkg::ActPushFront, $urandom, '0);
    send_item(olte_pkg::ActPushBack, $urandom, '0);
    send_item(olte_pkg::ActInsertUnique,
              {26'($urandom), 6'(DEPTH - 1)} ^ 32'h8000_0000, '0);
    send_item(olte_pkg::ActInsertUnique, 32'(list_mem[slot_at(5)]), '0);
    send_item(olte_pkg::ActReadIndex, '0, 6'(DEPTH - 1));
    send_item(olte_pkg::ActBack, '0, '0);
    send_item(olte_pkg::ActRemoveValue, 32'(list_mem[slot_at(DEPTH / 2)]), '0);
    send_item(olte_pkg::ActPushFront, $urandom, '0);
    for (int i = 0; i <= DEPTH; i++) begin
      send_item(olte_pkg::ActPopFront, '0, '0);
    end
  endtask

  // Random traffic in segments that alternately grow and shrink the list, so
  // that both the full and the empty ends are reached. Ends with a pause
  // until every result is back.
  task automatic test_random_traffic(input int num_items);
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    for (int i = 0; i < num_items; i++) begin
      send_random_item(((i / SEGMENT_ITEMS) % 2) == 0);
    end
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the
  // engine fills its output register and stops taking input.
  task automatic test_output_hold_off();
    wait_for_results();
    @(posedge clk);
    hold_request = HOLD_OFF_CYCLES;
    @(negedge clk);
    for (int i = 0; i < 16; i++) send_random_item(1'b1);
    wait_for_results();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_basic_actions();
    test_full_store();
    test_random_traffic(360);

    send_idle_pct = 48;
    recv_idle_pct = 13;
    test_random_traffic(360);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(350);
    test_output_hold_off();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
